// ===== hdl/spq_pkg.sv =====
package spq_pkg;

  // default queue depth
  localparam int CAPACITY_DEF = 64;

  // field widths
  localparam int ID_W     = 16;
  localparam int KIND_W   = 8;
  localparam int PRIO_W   = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;

  // opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_INVALID = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DUP     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EMPTY   = 3'd4;

  // one stored entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // one result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
    entry_t              entry;
  } result_t;

endpackage

// ===== hdl/stable_min_priority_queue_top.sv =====
// Stable minimum priority queue, up to CAPACITY entries of id, kind and
// signed priority, served lowest priority first and FIFO among equals.
// Command channel: a transaction is taken at a clock edge with start high
// and busy low; opcode 0 inserts (item_id, kind, prio), opcode 1 removes
// the head entry. Each command gives one result, held for exactly one cycle
// with done high: status, count after the operation, and the removed entry
// (zero unless a remove succeeded). The receiver cannot stall the result.
// An insert with id zero or a remove from an empty queue is answered from
// the idle state; a remove reads the head entry and answers from the remove
// state; an insert scans all queued entries and is then rejected as
// duplicate or full, or shifts the entries behind the insertion point and
// writes the new one there. The entries live in one memory with one read
// and one write port; the insert is bounded by the scan over all entries
// (one read a cycle) and then the shift of the entries behind the insertion
// point (one move a cycle).
// Busy is high for the whole operation, so a new command is taken from the
// cycle in which done shows. Reset empties the queue at once; the memory
// contents are not cleared.
module stable_min_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         opcode,
  input  logic [spq_pkg::ID_W-1:0]     item_id,
  input  logic [spq_pkg::KIND_W-1:0]   kind,
  input  logic [spq_pkg::PRIO_W-1:0]   prio,
  output logic                         done,
  output logic [spq_pkg::STATUS_W-1:0] status,
  output logic [spq_pkg::COUNT_W-1:0]  count,
  output logic [spq_pkg::ID_W-1:0]     out_item_id,
  output logic [spq_pkg::KIND_W-1:0]   out_kind,
  output logic [spq_pkg::PRIO_W-1:0]   out_prio
);

  localparam int IW = $clog2(CAPACITY);

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  spq_pkg::entry_t  mem_wdata;
  logic             mem_re;
  logic [IW-1:0]    mem_raddr;
  spq_pkg::entry_t  mem_rdata;
  spq_pkg::result_t res;

  // sequencer
  spq_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .item_id   (item_id),
    .kind      (kind),
    .prio      (prio),
    .busy      (busy),
    .res_v     (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // entry store
  spq_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result fields
  assign status      = res.status;
  assign count       = res.count;
  assign out_item_id = res.entry.id;
  assign out_kind    = res.entry.kind;
  assign out_prio    = res.entry.prio;

endmodule

// ===== hdl/spq_mem.sv =====
module spq_mem #(
  parameter int DEPTH = spq_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  spq_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output spq_pkg::entry_t rdata
);

  spq_pkg::entry_t mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/spq_ctrl.sv =====
module spq_ctrl #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       opcode,
  input  logic [spq_pkg::ID_W-1:0]   item_id,
  input  logic [spq_pkg::KIND_W-1:0] kind,
  input  logic [spq_pkg::PRIO_W-1:0] prio,
  output logic                       busy,
  output logic                       res_v,
  output spq_pkg::result_t           res,
  output logic                       mem_we,
  output logic [IW-1:0]              mem_waddr,
  output spq_pkg::entry_t            mem_wdata,
  output logic                       mem_re,
  output logic [IW-1:0]              mem_raddr,
  input  spq_pkg::entry_t            mem_rdata
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_SHIFT  = 2'd2;
  localparam logic [1:0] ST_REMOVE = 2'd3;

  logic [1:0]       state, state_next;
  logic [IW-1:0]    head, head_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [CW-1:0]    idx, idx_next;
  logic [CW-1:0]    rem, rem_next;
  logic [CW-1:0]    pos, pos_next;
  logic             dup, dup_next;
  logic             pend, pend_next;
  logic [IW-1:0]    wa, wa_next;
  spq_pkg::entry_t  new_e, new_e_next;
  logic             res_v_next;
  spq_pkg::result_t res_next;

  // logical queue index to memory address, circular from head
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  assign busy = (state != ST_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    head_next  = head;
    cnt_next   = cnt;
    idx_next   = idx;
    rem_next   = rem;
    pos_next   = pos;
    dup_next   = dup;
    pend_next  = pend;
    wa_next    = wa;
    new_e_next = new_e;
    res_v_next = 1'b0;
    res_next   = res;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = new_e;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          if (opcode == spq_pkg::OP_REMOVE) begin
            if (cnt == '0) begin
              res_v_next      = 1'b1;
              res_next.status = spq_pkg::STS_EMPTY;
              res_next.count  = '0;
              res_next.entry  = '0;
            end else begin
              mem_re     = 1'b1;
              mem_raddr  = head;
              state_next = ST_REMOVE;
            end
          end else begin
            new_e_next.id   = item_id;
            new_e_next.kind = kind;
            new_e_next.prio = prio;
            if (item_id == '0) begin
              res_v_next      = 1'b1;
              res_next.status = spq_pkg::STS_INVALID;
              res_next.count  = spq_pkg::COUNT_W'(cnt);
              res_next.entry  = '0;
            end else begin
              idx_next   = '0;
              pos_next   = '0;
              dup_next   = 1'b0;
              pend_next  = 1'b0;
              state_next = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // check the entry read last cycle
        if (pend) begin
          if (mem_rdata.id == new_e.id) begin
            dup_next = 1'b1;
          end
          if ($signed(mem_rdata.prio) <= $signed(new_e.prio)) begin
            pos_next = pos + CW'(1);
          end
        end
        if (idx != cnt) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head, idx);
          idx_next  = idx + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            if (dup) begin
              res_v_next      = 1'b1;
              res_next.status = spq_pkg::STS_DUP;
              res_next.count  = spq_pkg::COUNT_W'(cnt);
              res_next.entry  = '0;
              state_next      = ST_IDLE;
            end else if (cnt == CW'(CAPACITY)) begin
              res_v_next      = 1'b1;
              res_next.status = spq_pkg::STS_FULL;
              res_next.count  = spq_pkg::COUNT_W'(cnt);
              res_next.entry  = '0;
              state_next      = ST_IDLE;
            end else begin
              rem_next   = cnt - pos;
              idx_next   = cnt - CW'(1);
              state_next = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        // move the tail up by one, read one entry while writing the previous
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = wa;
          mem_wdata = mem_rdata;
        end
        if (rem != '0) begin
          mem_re    = 1'b1;
          mem_raddr = phys(head, idx);
          wa_next   = phys(head, idx + CW'(1));
          idx_next  = idx - CW'(1);
          rem_next  = rem - CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            mem_we          = 1'b1;
            mem_waddr       = phys(head, pos);
            mem_wdata       = new_e;
            cnt_next        = cnt + CW'(1);
            res_v_next      = 1'b1;
            res_next.status = spq_pkg::STS_OK;
            res_next.count  = spq_pkg::COUNT_W'(cnt + CW'(1));
            res_next.entry  = '0;
            state_next      = ST_IDLE;
          end
        end
      end

      ST_REMOVE: begin
        // head entry is on the read port now
        head_next       = phys(head, CW'(1));
        cnt_next        = cnt - CW'(1);
        res_v_next      = 1'b1;
        res_next.status = spq_pkg::STS_OK;
        res_next.count  = spq_pkg::COUNT_W'(cnt - CW'(1));
        res_next.entry  = mem_rdata;
        state_next      = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      cnt   <= '0;
      pend  <= 1'b0;
      res_v <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      res_v <= res_v_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    idx   <= idx_next;
    rem   <= rem_next;
    pos   <= pos_next;
    dup   <= dup_next;
    wa    <= wa_next;
    new_e <= new_e_next;
    res   <= res_next;
  end

endmodule

// ===== hdl/spq_checker.sv =====
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::COUNT_W-1:0]  count,
  input logic [spq_pkg::ID_W-1:0]     out_item_id,
  input logic [spq_pkg::KIND_W-1:0]   out_kind,
  input logic [spq_pkg::PRIO_W-1:0]   out_prio
);

  // a result only follows an accepted command or a running operation
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) || $past(busy)))
    else $error("result without a command");

  // the reported count moves only with a result
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> done)
    else $error("count changed without a result");

  // no entry data unless a remove succeeded
  a_zero_entry: assert property (@(posedge clk) disable iff (rst)
    (done && status != spq_pkg::STS_OK) |->
      (out_item_id == '0 && out_kind == '0 && out_prio == '0))
    else $error("entry fields set on a failed command");

  // empty and full statuses agree with the count
  a_empty_full: assert property (@(posedge clk) disable iff (rst)
    done |-> ((status != spq_pkg::STS_EMPTY || count == '0) &&
              (status != spq_pkg::STS_FULL ||
               count == spq_pkg::COUNT_W'(CAPACITY))))
    else $error("status does not match count");

endmodule

bind stable_min_priority_queue_top spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (.*);
